// ===== rtl/layered_gradient_noise_2d_core_defines.svh =====
// Assertion macros shared by the checker of the layered gradient noise core.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef LAYERED_GRADIENT_NOISE_2D_CORE_DEFINES_SVH
`define LAYERED_GRADIENT_NOISE_2D_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LGN2D_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgn2d assertion failed");

// Antecedent implies consequent later, after the delay given by n.
`define LGN2D_ASSERT_DELAYED(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("lgn2d delayed assertion failed");

`endif

// ===== rtl/lgn2d_pkg.sv =====
// Package for the layered gradient noise core: octave tables, hash constants,
// fixed-point widths and the elaboration-time gradient function. No dependencies.
`timescale 1ns / 1ps

package lgn2d_pkg;

    // Register stages inside one octave lane.
    localparam int LANE_DEPTH = 9;
    // Width of one weighted octave result.
    localparam int WN_W = 20;

    localparam logic [31:0] HASH_C1 = 32'd3284157443;
    localparam logic [31:0] HASH_C2 = 32'd1911520717;
    localparam logic [31:0] HASH_C3 = 32'd2048419325;

    localparam logic signed [21:0] NOISE_MAX = 22'sh1FFFFF;
    localparam logic signed [21:0] NOISE_MIN = 22'sh200000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Octave scale 0.125*1.5^i, unsigned Q16.
    localparam logic [21:0] OCT_SCALE [16] = '{
        22'd8192, 22'd12288, 22'd18432, 22'd27648, 22'd41472, 22'd62208,
        22'd93312, 22'd139968, 22'd209952, 22'd314928, 22'd472392, 22'd708588,
        22'd1062882, 22'd1594323, 22'd2391485, 22'd3587227
    };

    // Octave weight 2/1.375^i, unsigned Q16.
    localparam logic [17:0] OCT_WEIGHT [16] = '{
        18'd131072, 18'd95325, 18'd69327, 18'd50420, 18'd36669, 18'd26668,
        18'd19395, 18'd14106, 18'd10259, 18'd7461, 18'd5426, 18'd3946,
        18'd2870, 18'd2087, 18'd1518, 18'd1104
    };

    // Sine or cosine of r*102944 (Q30 angle), Taylor series in Q30, result Q15.
    // Evaluated at elaboration only to fill the gradient tables.
    function automatic logic [15:0] trig_q15(input logic [13:0] r, input logic want_sin);
        longint theta;
        longint t2;
        longint acc;
        longint v;
        longint q30;
        q30   = 64'sd1 << 30;
        theta = longint'(r) * 64'sd102944;
        t2    = (theta * theta) >>> 30;
        acc   = q30;
        if (want_sin) begin
            acc = q30 - (((t2 * acc) >>> 30) / 110);
            acc = q30 - (((t2 * acc) >>> 30) / 72);
            acc = q30 - (((t2 * acc) >>> 30) / 42);
            acc = q30 - (((t2 * acc) >>> 30) / 20);
            acc = q30 - (((t2 * acc) >>> 30) / 6);
            v   = (theta * acc) >>> 30;
        end else begin
            acc = q30 - (((t2 * acc) >>> 30) / 132);
            acc = q30 - (((t2 * acc) >>> 30) / 90);
            acc = q30 - (((t2 * acc) >>> 30) / 56);
            acc = q30 - (((t2 * acc) >>> 30) / 30);
            acc = q30 - (((t2 * acc) >>> 30) / 12);
            acc = q30 - (((t2 * acc) >>> 30) / 2);
            v   = acc;
        end
        if (v < 0) v = 0;
        if (v > q30) v = q30;
        v = (v + 64'sd16384) >>> 15;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

endpackage

// ===== rtl/layered_gradient_noise_2d_core.sv =====
// Top level of the layered gradient noise core: input register, one octave lane
// per layer, registered accumulation chain and saturation. Uses lgn2d_pkg, lgn2d_octave.
`timescale 1ns / 1ps

// Fractal 2D gradient noise, one point per clock. A transaction is accepted on
// any rising edge with start high; busy is always low because every stage moves
// forward each cycle and the receiver cannot stall. Each point produces one
// result, shown on noise for exactly one cycle with done high. The accepting
// edge loads the input register; from there the point passes through nine
// stages inside each octave lane (scale multiply, three hash multiplies,
// gradient table, dot products, two blends, weight multiply), one
// accumulation stage per octave and an output saturation register. Results
// leave in the order the points came in, back to back without gaps.
module layered_gradient_noise_2d_core
    import lgn2d_pkg::*;
#(
    parameter int LAYERS          = 8,
    parameter int ANGLE_BITS      = 10,
    parameter int COORD_FRAC_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    output logic               done,
    output logic signed [21:0] noise
);

    localparam int SUM_W = WN_W + $clog2(LAYERS + 1);
    localparam int ACC_W = (SUM_W > 23) ? SUM_W : 23;
    localparam int VLD_W = 1 + LANE_DEPTH + LAYERS;

    logic signed [31:0]      x_reg, y_reg;
    logic [VLD_W-1:0]        vld_reg;
    logic signed [WN_W-1:0]  wn [LAYERS];
    logic signed [WN_W-1:0]  wn_dly_reg [LAYERS][LAYERS];
    logic signed [ACC_W-1:0] acc_reg [LAYERS];
    logic signed [21:0]      noise_next, noise_reg;
    logic                    done_reg;

    // The pipeline never holds a transaction off.
    assign busy = 1'b0;

    // Advance the valid marks alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[VLD_W-2:0], start && !busy};
            done_reg <= vld_reg[VLD_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= coord_x;
        y_reg <= coord_y;
    end

    for (genvar i = 0; i < LAYERS; i++)
    begin : g_lane
        lgn2d_octave #(
            .LAYER_IDX       (i),
            .ANGLE_BITS      (ANGLE_BITS),
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
        ) u_octave (
            .clk (clk),
            .x   (x_reg),
            .y   (y_reg),
            .wn  (wn[i])
        );
    end

    // Accumulation chain: stage k adds octave k and carries the rest forward.
    always_ff @(posedge clk)
    begin
        acc_reg[0] <= ACC_W'(wn[0]);
        for (int j = 0; j < LAYERS; j++)
        begin
            wn_dly_reg[0][j] <= wn[j];
        end
        for (int k = 1; k < LAYERS; k++)
        begin
            acc_reg[k]    <= acc_reg[k-1] + ACC_W'(wn_dly_reg[k-1][k]);
            wn_dly_reg[k] <= wn_dly_reg[k-1];
        end
    end

    // Clamp the sum to the Q5.16 output range.
    always_comb
    begin
        priority if (acc_reg[LAYERS-1] > ACC_W'(NOISE_MAX))
            noise_next = NOISE_MAX;
        else if (acc_reg[LAYERS-1] < ACC_W'(NOISE_MIN))
            noise_next = NOISE_MIN;
        else
            noise_next = 22'(acc_reg[LAYERS-1]);
    end

    always_ff @(posedge clk)
    begin
        noise_reg <= noise_next;
    end

    assign done  = done_reg;
    assign noise = noise_reg;

endmodule

// ===== rtl/lgn2d_octave.sv =====
// One octave lane of the layered gradient noise core: scale, corner hash,
// gradient lookup, dot products, quintic fade, blend and weight. Uses lgn2d_pkg.
`timescale 1ns / 1ps

module lgn2d_octave
    import lgn2d_pkg::*;
#(
    parameter int LAYER_IDX       = 0,
    parameter int ANGLE_BITS      = 10,
    parameter int COORD_FRAC_BITS = 12
)
(
    input  logic                    clk,
    input  logic signed [31:0]      x,
    input  logic signed [31:0]      y,
    output logic signed [WN_W-1:0]  wn
);

    localparam int SX_W  = 48;
    localparam int ROM_W = ANGLE_BITS - 2;
    localparam int ROM_D = 2 ** ROM_W;
    localparam logic [22:0] SCALE  = {1'b0, OCT_SCALE[LAYER_IDX]};
    localparam logic [18:0] WEIGHT = {1'b0, OCT_WEIGHT[LAYER_IDX]};

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic logic signed [21:0] fade_mul(input logic signed [21:0] p,
                                                    input logic [15:0] t);
        logic signed [38:0] m;
        m = p * $signed({1'b0, t});
        return 22'(m >>> 16);
    endfunction

    function automatic logic signed [18:0] blend(input logic signed [18:0] a,
                                                 input logic signed [18:0] b,
                                                 input logic signed [17:0] u);
        logic signed [19:0] diff;
        logic signed [37:0] m;
        diff = 20'(b) - 20'(a);
        m    = diff * u;
        return 19'(20'(a) + 20'(m >>> 16));
    endfunction

    // Gradient tables, one quadrant, indexed by the hash bits below the quadrant.
    logic [15:0] cos_rom [ROM_D];
    logic [15:0] sin_rom [ROM_D];

    for (genvar g = 0; g < ROM_D; g++) begin : g_rom
        localparam logic [13:0] PHASE = 14'(g << (16 - ANGLE_BITS));
        assign cos_rom[g] = trig_q15(PHASE, 1'b0);
        assign sin_rom[g] = trig_q15(PHASE, 1'b1);
    end

    // Scale stage
    logic signed [54:0]     px_prod, py_prod;
    logic signed [SX_W-1:0] sx_reg, sy_reg;

    // Cell and first hash multiply
    logic [31:0]        cx0, cy0;
    logic [31:0]        a0_next, a1_next, a0_reg, a1_reg, y0_reg, y1_reg;
    logic [15:0]        f3_next [2];
    logic [15:0]        f3_reg  [2];
    logic signed [20:0] fq      [2];
    logic signed [37:0] fq_prod [2];
    logic signed [21:0] p3_next [2];
    logic signed [21:0] p3_reg  [2];

    // Second hash multiply
    logic [31:0]        b_next [4];
    logic [31:0]        b_reg  [4];
    logic [31:0]        a0_t4_reg, a1_t4_reg;
    logic [15:0]        f4_reg [2];
    logic signed [21:0] p4_reg [2];

    // Third hash multiply
    logic [31:0]        h_next [4];
    logic [31:0]        h_reg  [4];
    logic [15:0]        f5_reg [2];
    logic signed [21:0] p5_reg [2];

    // Gradient lookup
    logic signed [15:0] gx_next [4];
    logic signed [15:0] gy_next [4];
    logic signed [15:0] gx_reg  [4];
    logic signed [15:0] gy_reg  [4];
    logic [15:0]        f6_reg  [2];
    logic signed [17:0] u6_reg  [2];

    // Dot products, blends, weight
    logic signed [33:0] dsum   [4];
    logic signed [18:0] d_next [4];
    logic signed [18:0] d_reg  [4];
    logic signed [17:0] u7_reg [2];
    logic signed [18:0] lx_reg [2];
    logic signed [17:0] u8_reg;
    logic signed [18:0] n_reg;
    logic signed [37:0] w_prod;
    logic signed [WN_W-1:0] wn_reg;

    assign px_prod = x * $signed(SCALE);
    assign py_prod = y * $signed(SCALE);

    always_comb
    begin
        cx0 = sx_reg[COORD_FRAC_BITS +: 32];
        cy0 = sy_reg[COORD_FRAC_BITS +: 32];
        // (x0+1)*C1 equals x0*C1 + C1 modulo 2^32
        a0_next = cx0 * HASH_C1;
        a1_next = a0_next + HASH_C1;
        f3_next[0] = 16'(sx_reg[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
        f3_next[1] = 16'(sy_reg[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
        for (int k = 0; k < 2; k++)
        begin
            fq[k]      = $signed({5'd0, f3_next[k]}) * 21'sd6 - 21'sd983040;
            fq_prod[k] = $signed({1'b0, f3_next[k]}) * fq[k];
            p3_next[k] = 22'(fq_prod[k] >>> 16) + 22'sd655360;
        end
    end

    // Corner c: bit 0 selects x0+1, bit 1 selects y0+1.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            b_next[c] = (((c & 2) != 0 ? y1_reg : y0_reg)
                         ^ rot16((c & 1) != 0 ? a1_reg : a0_reg)) * HASH_C2;
            h_next[c] = (((c & 1) != 0 ? a1_t4_reg : a0_t4_reg) ^ rot16(b_reg[c]))
                        * HASH_C3;
        end
    end

    always_comb
    begin
        logic [ROM_W-1:0] idx;
        logic signed [15:0] cv;
        logic signed [15:0] sv;
        for (int c = 0; c < 4; c++)
        begin
            idx = h_reg[c][29 -: ROM_W];
            cv  = $signed(cos_rom[idx]);
            sv  = $signed(sin_rom[idx]);
            unique case (h_reg[c][31:30])
                QUAD_0:  begin gx_next[c] = cv;  gy_next[c] = sv;  end
                QUAD_1:  begin gx_next[c] = -sv; gy_next[c] = cv;  end
                QUAD_2:  begin gx_next[c] = -cv; gy_next[c] = -sv; end
                QUAD_3:  begin gx_next[c] = sv;  gy_next[c] = -cv; end
                default: begin gx_next[c] = cv;  gy_next[c] = sv;  end
            endcase
        end
    end

    always_comb
    begin
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        for (int c = 0; c < 4; c++)
        begin
            // f - 1.0 in Q16 is f with a set sign bit
            dx = $signed({((c & 1) != 0), f6_reg[0]});
            dy = $signed({((c & 2) != 0), f6_reg[1]});
            dsum[c]   = dx * gx_reg[c] + dy * gy_reg[c];
            d_next[c] = 19'(dsum[c] >>> 15);
        end
    end

    assign w_prod = n_reg * $signed(WEIGHT);

    always_ff @(posedge clk)
    begin
        sx_reg <= SX_W'(px_prod >>> 16);
        sy_reg <= SX_W'(py_prod >>> 16);

        a0_reg <= a0_next;
        a1_reg <= a1_next;
        y0_reg <= cy0;
        y1_reg <= cy0 + 32'd1;

        a0_t4_reg <= a0_reg;
        a1_t4_reg <= a1_reg;
        for (int c = 0; c < 4; c++)
        begin
            b_reg[c]  <= b_next[c];
            h_reg[c]  <= h_next[c];
            gx_reg[c] <= gx_next[c];
            gy_reg[c] <= gy_next[c];
            d_reg[c]  <= d_next[c];
        end
        for (int k = 0; k < 2; k++)
        begin
            f3_reg[k] <= f3_next[k];
            p3_reg[k] <= p3_next[k];
            f4_reg[k] <= f3_reg[k];
            p4_reg[k] <= fade_mul(p3_reg[k], f3_reg[k]);
            f5_reg[k] <= f4_reg[k];
            p5_reg[k] <= fade_mul(p4_reg[k], f4_reg[k]);
            f6_reg[k] <= f5_reg[k];
            u6_reg[k] <= 18'(fade_mul(p5_reg[k], f5_reg[k]));
            u7_reg[k] <= u6_reg[k];
        end

        lx_reg[0] <= blend(d_reg[0], d_reg[1], u7_reg[0]);
        lx_reg[1] <= blend(d_reg[2], d_reg[3], u7_reg[0]);
        u8_reg    <= u7_reg[1];
        n_reg     <= blend(lx_reg[0], lx_reg[1], u8_reg);
        wn_reg    <= WN_W'(w_prod >>> 16);
    end

    assign wn = wn_reg;

endmodule

// ===== rtl/lgn2d_checker.sv =====
// Port-level checker for the layered gradient noise core and its bind.
// Uses layered_gradient_noise_2d_core_defines.svh and lgn2d_pkg.
`timescale 1ns / 1ps
`include "layered_gradient_noise_2d_core_defines.svh"

module lgn2d_checker
    import lgn2d_pkg::*;
#(
    parameter int LAYERS = 8
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [21:0] noise
);

    localparam int LAT = 2 + LANE_DEPTH + LAYERS;

    logic accepted;
    assign accepted = start && !busy;

    // Every accepted transaction yields a result with done high.
    `LGN2D_ASSERT_DELAYED(a_result_follows, accepted, LAT, done)
    // Every result traces back to an accepted transaction.
    `LGN2D_ASSERT_IMPLY(a_no_invented, done, $past(accepted, LAT))
    // A result never shows an unknown value.
    `LGN2D_ASSERT_IMPLY(a_known_value, done, !$isunknown(noise))

endmodule

bind layered_gradient_noise_2d_core lgn2d_checker #(
    .LAYERS (LAYERS)
) u_lgn2d_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .noise (noise)
);
